@@ hw/rtl/ttcs_pkg.sv @@
// Shared types and constants for the text terminal cursor/scroll unit.
// No dependencies.
`default_nettype none

package ttcs_pkg;

  localparam int COLUMNS_DEF    = 80;
  localparam int ROWS_DEF       = 25;
  localparam int CELL_W         = 16;
  localparam int CELL_COUNT_DEF = COLUMNS_DEF * ROWS_DEF;

  localparam logic [7:0]        NEWLINE_CODE = 8'd10;
  localparam logic [7:0]        SPACE_CODE   = 8'd32;
  localparam logic [7:0]        COLOR_RESET  = 8'd15;
  localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0F20;

  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } ttcs_in_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
    logic        scrolled;
  } ttcs_out_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FILL
  } ttcs_state_e;

endpackage

`default_nettype wire

@@ hw/rtl/ttcs_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Defaults come from ttcs_pkg.
`default_nettype none

module ttcs_ram #(
  parameter int WIDTH = ttcs_pkg::CELL_W,
  parameter int DEPTH = ttcs_pkg::CELL_COUNT_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hw/rtl/text_terminal_cursor_scroll_unit.sv @@
// Text terminal screen store with cursor and scroll, ROWS x COLUMNS cells.
// Puts pass the result register; reads pass the RAM read register, then
// the result register. One put per cycle while the output is not stalled;
// a read stalls input until its result is registered, a scroll while the
// new bottom row is filled. Reset: cursor to 0, color 15; a clearing
// pass writes 0x0F20 to every cell, input stalled meanwhile.
`default_nettype none

module text_terminal_cursor_scroll_unit #(
  parameter int COLUMNS = ttcs_pkg::COLUMNS_DEF,
  parameter int ROWS    = ttcs_pkg::ROWS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire ttcs_pkg::ttcs_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output ttcs_pkg::ttcs_out_t      out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [7:0]          cfg_data_i
);

  import ttcs_pkg::*;

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int AW = $clog2(CELL_COUNT);
  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLUMNS);
  localparam int IW = ((AW > 11) ? AW : 11) + 1;

  ttcs_state_e state_q, state_d;

  logic [RW-1:0]     row_q, row_d;
  logic [CW-1:0]     col_q, col_d;
  logic [AW-1:0]     lin_q, lin_d;
  logic [AW-1:0]     base_q, base_d;
  logic [AW-1:0]     sweep_q, sweep_d;
  logic [7:0]        color_q;
  logic [CELL_W-1:0] fill_cell_q;
  logic              rd_ok_q;
  logic              out_valid_q, out_valid_d;
  ttcs_out_t         out_q, out_d;

  logic              accept;
  logic              is_put, is_newline, do_scroll;
  logic [RW:0]       row_inc;
  logic [CW:0]       col_inc;
  logic [AW:0]       lin_nl;
  logic [AW:0]       base_inc;
  logic [RW-1:0]     put_row;
  logic [CW-1:0]     put_col;
  logic [AW-1:0]     put_lin;
  logic              sweep_last;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] a,
                                              input logic [AW-1:0] base);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, base};
    if (s >= (AW+1)'(CELL_COUNT)) begin
      s = s - (AW+1)'(CELL_COUNT);
    end
    return s[AW-1:0];
  endfunction

  assign in_stall_o  = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign is_put      = (in_data_i.mode == MODE_PUT);
  assign is_newline  = (in_data_i.char_code == NEWLINE_CODE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // cursor advance for a put word
  always_comb begin
    row_inc   = {1'b0, row_q} + (RW+1)'(1);
    col_inc   = {1'b0, col_q} + (CW+1)'(1);
    lin_nl    = {1'b0, lin_q} + (AW+1)'(COLUMNS) - (AW+1)'(col_q);
    do_scroll = 1'b0;
    put_row   = row_q;
    put_col   = col_q;
    put_lin   = lin_q;
    if (is_newline || (col_inc == (CW+1)'(COLUMNS))) begin
      put_col = '0;
      if (row_inc == (RW+1)'(ROWS)) begin
        do_scroll = 1'b1;
        put_row   = RW'(ROWS - 1);
        put_lin   = AW'((ROWS - 1) * COLUMNS);
      end else begin
        put_row = row_inc[RW-1:0];
        put_lin = is_newline ? lin_nl[AW-1:0] : AW'({1'b0, lin_q} + (AW+1)'(1));
      end
    end else begin
      put_col = col_inc[CW-1:0];
      put_lin = AW'({1'b0, lin_q} + (AW+1)'(1));
    end
  end

  assign sweep_last = (state_q == ST_CLEAR) ? (sweep_q == AW'(CELL_COUNT - 1))
                                            : (sweep_q == AW'(COLUMNS - 1));
  assign base_inc   = {1'b0, base_q} + (AW+1)'(COLUMNS);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (!is_put) begin
            state_d = ST_READ;
          end else if (do_scroll) begin
            state_d = ST_FILL;
          end
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
      end
      ST_FILL: begin
        if (sweep_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs: RAM control, cursor, result register
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = phys_addr(lin_q, base_q);
    ram_wdata   = {color_q, in_data_i.char_code};
    ram_raddr   = phys_addr(AW'(in_data_i.cell_index), base_q);
    sweep_d     = sweep_q;
    base_d      = base_q;
    row_d       = row_q;
    col_d       = col_q;
    lin_d       = lin_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        ram_wdata = RESET_CELL;
        sweep_d   = sweep_last ? '0 : sweep_q + AW'(1);
      end
      ST_IDLE: begin
        if (accept && is_put) begin
          ram_we              = !is_newline;
          row_d               = put_row;
          col_d               = put_col;
          lin_d               = put_lin;
          out_d.cell_value    = '0;
          out_d.cursor_row    = 5'(put_row);
          out_d.cursor_column = 7'(put_col);
          out_d.scrolled      = do_scroll;
          out_valid_d         = 1'b1;
        end
      end
      ST_READ: begin
        out_d.cell_value    = rd_ok_q ? ram_rdata : '0;
        out_d.cursor_row    = 5'(row_q);
        out_d.cursor_column = 7'(col_q);
        out_d.scrolled      = 1'b0;
        out_valid_d         = 1'b1;
      end
      ST_FILL: begin
        // old top row becomes the new bottom row
        ram_we    = 1'b1;
        ram_waddr = base_q + sweep_q;
        ram_wdata = fill_cell_q;
        sweep_d   = sweep_last ? '0 : sweep_q + AW'(1);
        if (sweep_last) begin
          base_d = (base_inc == (AW+1)'(CELL_COUNT)) ? '0 : base_inc[AW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      sweep_q     <= '0;
      base_q      <= '0;
      row_q       <= '0;
      col_q       <= '0;
      lin_q       <= '0;
      color_q     <= COLOR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      base_q      <= base_d;
      row_q       <= row_d;
      col_q       <= col_d;
      lin_q       <= lin_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        color_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      rd_ok_q     <= (IW'(in_data_i.cell_index) < IW'(CELL_COUNT));
      fill_cell_q <= {color_q, SPACE_CODE};
    end
  end

  ttcs_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  a_read_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_data_i.mode == MODE_READ)) |=> ##1 out_valid_o)
    else $error("read word produced no result");

  a_cursor_linear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(row_q) * COLUMNS + 32'(col_q)) == 32'(lin_q))
    else $error("linear cursor out of step with row/column");

  a_base_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(base_q) < CELL_COUNT) && (32'(row_q) < ROWS))
    else $error("scroll base or cursor row out of range");

endmodule

`default_nettype wire

@@ bench/tb_text_terminal_cursor_scroll_unit.sv @@
// Self-checking bench for text_terminal_cursor_scroll_unit: drives put/read words,
// predicts screen, cursor and scroll flags in a scoreboard class, compares every result.
// Depends on ttcs_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb_text_terminal_cursor_scroll_unit;
  import ttcs_pkg::*;

  class terminal_scoreboard;
    logic [CELL_W-1:0] screen [CELL_COUNT_DEF];
    int                row;
    int                col;
    logic [7:0]        color;
    ttcs_out_t         cursor_reports [$];
    int                errors;

    function new();
      foreach (screen[i]) screen[i] = RESET_CELL;
      row    = 0;
      col    = 0;
      color  = COLOR_RESET;
      errors = 0;
    endfunction

    function void set_color(logic [7:0] c);
      color = c;
    endfunction

    function void scroll_screen();
      int i;
      for (i = 0; i + COLUMNS_DEF < CELL_COUNT_DEF; i++) screen[i] = screen[i + COLUMNS_DEF];
      for (i = CELL_COUNT_DEF - COLUMNS_DEF; i < CELL_COUNT_DEF; i++) begin
        screen[i] = {color, SPACE_CODE};
      end
    endfunction

    function void take_word(ttcs_in_t w);
      ttcs_out_t r;
      int        pos;
      r = '0;
      if (w.mode == MODE_READ) begin
        if (w.cell_index < CELL_COUNT_DEF) r.cell_value = screen[w.cell_index];
      end else begin
        if (w.char_code == NEWLINE_CODE) begin
          row++;
          col = 0;
        end else begin
          pos = row * COLUMNS_DEF + col;
          if (pos < CELL_COUNT_DEF) screen[pos] = {color, w.char_code};
          col++;
          if (col >= COLUMNS_DEF) begin
            col = 0;
            row++;
          end
        end
        if (row >= ROWS_DEF) begin
          scroll_screen();
          row = ROWS_DEF - 1;
          col = 0;
          r.scrolled = 1'b1;
        end
      end
      r.cursor_row    = row[4:0];
      r.cursor_column = col[6:0];
      cursor_reports.push_back(r);
    endfunction

    function void check_report(ttcs_out_t got);
      ttcs_out_t exp;
      if (cursor_reports.size() == 0) begin
        $error("unexpected result word %h", got);
        errors++;
        return;
      end
      exp = cursor_reports.pop_front();
      if (got.cell_value !== exp.cell_value) begin
        $error("cell_value: expected %h, got %h", exp.cell_value, got.cell_value);
        errors++;
      end
      if (got.cursor_row !== exp.cursor_row) begin
        $error("cursor_row: expected %0d, got %0d", exp.cursor_row, got.cursor_row);
        errors++;
      end
      if (got.cursor_column !== exp.cursor_column) begin
        $error("cursor_column: expected %0d, got %0d", exp.cursor_column, got.cursor_column);
        errors++;
      end
      if (got.scrolled !== exp.scrolled) begin
        $error("scrolled: expected %b, got %b", exp.scrolled, got.scrolled);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  ttcs_in_t   in_data_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b1;
  ttcs_out_t  out_data_o;
  logic       cfg_we_i    = 1'b0;
  logic [7:0] cfg_data_i  = '0;

  terminal_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  bit hold_req      = 1'b0;

  text_terminal_cursor_scroll_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver stall; a hold request stalls for a long run so the unit backs up
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && sb != null) begin
      if (cfg_we_i) sb.set_color(cfg_data_i);
      if (in_valid_i && !in_stall_o) sb.take_word(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_report(out_data_o);
    end
  end

  initial begin
    #50_000_000;
    $display("FAIL text_terminal_cursor_scroll_unit");
    $finish;
  end

  task automatic send_word(input ttcs_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_fields(input logic m, input int ch, input int idx);
    ttcs_in_t w;
    w.mode       = m;
    w.char_code  = ch[7:0];
    w.cell_index = idx[10:0];
    send_word(w);
  endtask

  // called right after the last accepted word, so valid drops in that same step
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.cursor_reports.size() > 0) @(posedge clk_i);
    repeat (COLUMNS_DEF + 20) @(posedge clk_i);
  endtask

  task automatic write_color(input logic [7:0] c);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= c;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic run_random(input int count, input int newline_pct, input int read_pct,
                            input int hold_at);
    ttcs_in_t w;
    int       i;
    for (i = 0; i < count; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      w.mode       = ($urandom_range(99) < read_pct) ? MODE_READ : MODE_PUT;
      w.cell_index = 11'($urandom_range(2047));
      w.char_code  = 8'($urandom_range(255));
      if (w.mode == MODE_PUT && $urandom_range(99) < newline_pct) w.char_code = NEWLINE_CODE;
      send_word(w);
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 22;
    recv_idle_pct = 67;
    send_fields(MODE_READ, 0, 0);
    send_fields(MODE_READ, 255, CELL_COUNT_DEF - 1);
    send_fields(MODE_READ, 0, CELL_COUNT_DEF);
    send_fields(MODE_READ, 255, 2047);
    send_fields(MODE_PUT, 8'h00, 2047);
    send_fields(MODE_PUT, 8'hFF, 0);
    send_fields(MODE_PUT, 65, 5);
    send_fields(MODE_PUT, 13, 0);
    send_fields(MODE_PUT, 9, 0);
    send_fields(MODE_PUT, NEWLINE_CODE, 0);
    send_fields(MODE_PUT, SPACE_CODE, 0);
    send_fields(MODE_PUT, NEWLINE_CODE, 2047);
    send_fields(MODE_READ, 0, 0);
    send_fields(MODE_READ, 0, 1);
    send_fields(MODE_READ, 0, 3);
    send_fields(MODE_READ, 0, 4);
    send_fields(MODE_READ, 0, COLUMNS_DEF);
    send_fields(MODE_READ, 0, 5);
    drain();

    write_color(8'h00);
    run_random(450, 3, 25, -1);
    drain();

    send_idle_pct = 67;
    recv_idle_pct = 22;
    write_color(8'hFF);
    run_random(450, 0, 10, 60);
    drain();

    write_color(8'($urandom_range(255)));
    run_random(450, 10, 30, -1);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_color(8'h1E);
    run_random(450, 5, 20, 100);
    drain();

    if (sb.errors == 0) begin
      $display("PASS text_terminal_cursor_scroll_unit");
    end else begin
      $display("FAIL text_terminal_cursor_scroll_unit");
    end
    $finish;
  end

endmodule
